// File: rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, types and helpers for the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  localparam int COORD_W           = 6;
  localparam int CHAN_W            = 2;
  localparam int IN_DATA_W         = 4 * COORD_W;   // 24 bits, already whole bytes
  localparam int OUT_DATA_W        = 16;            // two coordinates padded to bytes
  localparam int CMP_W             = 11;            // holds canvas sizes up to 2047
  localparam int DEF_CANVAS_WIDTH  = 64;
  localparam int DEF_CANVAS_HEIGHT = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = 1;
  localparam int QCNT_W            = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  // Classified line command as it sits in the queue
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t mag_x;
    coord_t mag_y;
    logic   neg_x;
    logic   neg_y;
    coord_t steps;
    chan_t  channel;
  } line_cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // start + floor(i*d/steps) from quotient q and remainder r of i*|d|/steps
  function automatic coord_t dda_pos(coord_t start, logic neg, coord_t q, coord_t r);
    coord_t ceil_q;
    ceil_q = q + coord_t'(r != '0);
    if (neg) begin
      return start - ceil_q;
    end else begin
      return start + q;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Accept line command beats and classify them into direction, magnitude
// and step count before they enter the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_front
  import dda_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // start_x, start_y, end_x, end_y
  input  logic [CHAN_W-1:0]    in_tuser,   // channel
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output line_cmd_t            q_wdata
);

  coord_t             sx, sy, ex, ey;
  logic [COORD_W:0]   dx, dy;
  logic [COORD_W:0]   dx_neg, dy_neg;
  coord_t             ax, ay;

  assign sx = in_tdata[COORD_W-1:0];
  assign sy = in_tdata[2*COORD_W-1:COORD_W];
  assign ex = in_tdata[3*COORD_W-1:2*COORD_W];
  assign ey = in_tdata[4*COORD_W-1:3*COORD_W];

  assign dx     = {1'b0, ex} - {1'b0, sx};
  assign dy     = {1'b0, ey} - {1'b0, sy};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
  assign ay     = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];

  always_comb begin
    q_wdata.start_x = sx;
    q_wdata.start_y = sy;
    q_wdata.mag_x   = ax;
    q_wdata.mag_y   = ay;
    q_wdata.neg_x   = dx[COORD_W];
    q_wdata.neg_y   = dy[COORD_W];
    q_wdata.steps   = (ax > ay) ? ax : ay;
    q_wdata.channel = in_tuser;
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;

endmodule

`default_nettype wire

// File: rtl/dda_queue.sv
// ----------------------------------------------------------------------------
// dda_queue
// Short command queue between the front and the pixel walker.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_queue
  import dda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  line_cmd_t wdata,
  input  logic      pop,
  output line_cmd_t rdata,
  output q_stat_t   stat
);

  line_cmd_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Pixel walker: step one pixel a cycle (output stalls hold it) through the
// queued line by exact quotient/remainder DDA; clip to canvas; drive output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_back
  import dda_pkg::*;
#(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_stat_t               q_stat,
  input  line_cmd_t             q_rdata,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic [CHAN_W-1:0]     out_tuser,  // pixel_channel
  output logic                  out_tlast   // last_pixel
);

  localparam logic [CMP_W-1:0] X_LIM = CMP_W'(CANVAS_WIDTH);
  localparam logic [CMP_W-1:0] Y_LIM = CMP_W'(CANVAS_HEIGHT);

  line_cmd_t        cmd_r, cmd_nxt;
  logic             busy_r, busy_nxt;
  coord_t           i_r, i_nxt;
  coord_t           qx_r, qx_nxt, rx_r, rx_nxt;
  coord_t           qy_r, qy_nxt, ry_r, ry_nxt;
  logic             out_valid_r, out_valid_nxt;
  coord_t           pix_x_r, pix_y_r;
  chan_t            pix_ch_r;
  logic             pix_last_r;

  logic             advance, at_end;
  coord_t           cur_x, cur_y, nx_x, nx_y;
  logic             cur_ok, nx_ok, is_last;
  logic [COORD_W:0] sum_x, sum_y;
  logic             wrap_x, wrap_y;
  coord_t           sx_q, sy_q, sx_r, sy_r;

  assign q_pop   = !busy_r && !q_stat.empty;
  assign advance = busy_r && (!out_valid_r || out_tready);
  assign at_end  = (i_r == cmd_r.steps);

  // One remainder step per axis: r + |d| stays below 2*steps
  assign sum_x  = {1'b0, rx_r} + {1'b0, cmd_r.mag_x};
  assign sum_y  = {1'b0, ry_r} + {1'b0, cmd_r.mag_y};
  assign wrap_x = (sum_x >= {1'b0, cmd_r.steps});
  assign wrap_y = (sum_y >= {1'b0, cmd_r.steps});
  assign sx_r   = wrap_x ? coord_t'(sum_x - {1'b0, cmd_r.steps}) : sum_x[COORD_W-1:0];
  assign sy_r   = wrap_y ? coord_t'(sum_y - {1'b0, cmd_r.steps}) : sum_y[COORD_W-1:0];
  assign sx_q   = qx_r + coord_t'(wrap_x);
  assign sy_q   = qy_r + coord_t'(wrap_y);

  assign cur_x = dda_pos(cmd_r.start_x, cmd_r.neg_x, qx_r, rx_r);
  assign cur_y = dda_pos(cmd_r.start_y, cmd_r.neg_y, qy_r, ry_r);
  assign nx_x  = dda_pos(cmd_r.start_x, cmd_r.neg_x, sx_q, sx_r);
  assign nx_y  = dda_pos(cmd_r.start_y, cmd_r.neg_y, sy_q, sy_r);

  assign cur_ok = ({{(CMP_W-COORD_W){1'b0}}, cur_x} < X_LIM) &&
                  ({{(CMP_W-COORD_W){1'b0}}, cur_y} < Y_LIM);
  assign nx_ok  = ({{(CMP_W-COORD_W){1'b0}}, nx_x} < X_LIM) &&
                  ({{(CMP_W-COORD_W){1'b0}}, nx_y} < Y_LIM);

  // On-canvas pixels form one run, so a visible pixel whose successor is
  // off canvas closes the line.
  assign is_last = at_end || !nx_ok;

  always_comb begin
    cmd_nxt       = cmd_r;
    busy_nxt      = busy_r;
    i_nxt         = i_r;
    qx_nxt        = qx_r;
    rx_nxt        = rx_r;
    qy_nxt        = qy_r;
    ry_nxt        = ry_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cmd_nxt  = q_rdata;
      busy_nxt = 1'b1;
      i_nxt    = '0;
      qx_nxt   = '0;
      rx_nxt   = '0;
      qy_nxt   = '0;
      ry_nxt   = '0;
    end else if (advance) begin
      if (cur_ok) begin
        out_valid_nxt = 1'b1;
      end
      if (at_end || (cur_ok && !nx_ok)) begin
        busy_nxt = 1'b0;
      end else begin
        i_nxt  = i_r + 1'b1;
        qx_nxt = sx_q;
        rx_nxt = sx_r;
        qy_nxt = sy_q;
        ry_nxt = sy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    i_r   <= i_nxt;
    qx_r  <= qx_nxt;
    rx_r  <= rx_nxt;
    qy_r  <= qy_nxt;
    ry_r  <= ry_nxt;
    if (advance && cur_ok) begin
      pix_x_r    <= cur_x;
      pix_y_r    <= cur_y;
      pix_ch_r   <= cmd_r.channel;
      pix_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*COORD_W){1'b0}}, pix_y_r, pix_x_r};
  assign out_tuser  = pix_ch_r;
  assign out_tlast  = pix_last_r;

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (i_r <= cmd_r.steps))
    else $error("pixel index past step count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cmd_r.steps != '0)) |-> ((rx_r < cmd_r.steps) && (ry_r < cmd_r.steps)))
    else $error("DDA remainder out of range");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((qx_r <= cmd_r.mag_x) && (qy_r <= cmd_r.mag_y)))
    else $error("DDA quotient past line delta");

endmodule

`default_nettype wire

// File: rtl/dda_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// DDA line rasterizer: one line command in, its pixels out in order.
// ----------------------------------------------------------------------------
// A command beat is queued, then loaded into the walker once it is free.
// The walker walks a line of steps = max(|dx|,|dy|) one pixel a cycle while
//   the output is not stalled, registering each visible pixel for output.
// A two-entry command queue lets new commands enter while a line is walked.
// Reset: synchronous, active-low rst_n clears the queue, walker and output
//   valid; payload registers are not reset.
`default_nettype none

module dda_line_rasterizer_top
  import dda_pkg::*;
#(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // line command beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  input  logic [CHAN_W-1:0]     in_tuser,   // channel
  // pixel beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic [CHAN_W-1:0]     out_tuser,  // pixel_channel
  output logic                  out_tlast   // last_pixel
);

  q_stat_t   q_stat;
  logic      q_push;
  logic      q_pop;
  line_cmd_t q_wdata;
  line_cmd_t q_rdata;

  // Front: take the beat, work out direction, magnitude and step count
  dda_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Hold classified commands until the walker is free
  dda_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: walk the line one pixel a cycle while the output is not stalled,
  // drop off-canvas pixels and mark the final visible one with tlast
  dda_back #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
